// ===== rtl/lsfp_pkg.sv =====
`default_nettype none
package lsfp_pkg;

   // Frame layout
   localparam logic [7:0] SYNC_BYTE    = 8'h59;
   localparam int         PAYLOAD_LEN  = 6;
   localparam int         IDX_W        = $clog2(PAYLOAD_LEN);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_LEN - 1);
   localparam logic [IDX_W-1:0] IDX_DIST_LO = IDX_W'(0);
   localparam logic [IDX_W-1:0] IDX_DIST_HI = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_SIGNAL  = IDX_W'(4);

   // Sum of both sync bytes, the checksum's starting value
   localparam logic [7:0] SUM_SEED     = 8'(SYNC_BYTE + SYNC_BYTE);

   // Distance rules
   localparam int         DIST_W       = 13;
   localparam logic [15:0] RANGE_MIN   = 16'd40;
   localparam logic [15:0] RANGE0_END  = 16'd1200;
   localparam logic [15:0] RANGE1_END  = 16'd2200;
   localparam logic [7:0]  LONG_ITIME  = 8'd7;
   localparam logic [7:0]  SIG_MIN     = 8'd7;
   localparam logic signed [DIST_W-1:0] ITIME_OFFSET = 13'sd13;
   localparam logic signed [DIST_W-1:0] DIST_INVALID = -13'sd1;

   // Sensor type codes
   localparam logic SENSOR_SHORT = 1'b0;
   localparam logic SENSOR_LONG  = 1'b1;

   localparam int ERR_W = 16;

endpackage
`default_nettype wire

// ===== rtl/lidar_serial_frame_parser.sv =====
`default_nettype none
// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_stall      req_rx_byte[7:0]
// rsp_      out        rsp_valid / rsp_stall      rsp_checksum_ok, rsp_distance_cm[12:0] s,
//                                                 rsp_error_count[15:0]
// csr_      in         csr_write_enable           csr_write_data (sensor type)
//
// One byte per cycle unless stalled; a checksum byte gives its response in the next cycle.
// The rate is set by the single response register: bytes stall only while a
// response is held there by rsp_stall.
// Reset (synchronous, active high) returns to sync hunting with zero distance and
// zero error count; there is no clearing pass.
module lidar_serial_frame_parser (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_checksum_ok,
   output logic signed [lsfp_pkg::DIST_W-1:0] rsp_distance_cm,
   output logic [lsfp_pkg::ERR_W-1:0]         rsp_error_count,
   input  wire                                csr_write_enable,
   input  wire                                csr_write_data
);

   typedef enum logic [1:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_PAYLOAD,
      PH_CKSUM
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic [lsfp_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [7:0]                         sum_ff, sum_in;
   logic [7:0]                         dist_lo_ff, dist_hi_ff, signal_ff;
   logic signed [lsfp_pkg::DIST_W-1:0] held_ff, held_in;
   logic [lsfp_pkg::ERR_W-1:0]         err_ff, err_in;
   logic                               sensor_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_ok_ff;

   logic                               accept;
   logic                               finish;
   logic                               sum_match;
   logic [15:0]                        dist_raw;
   logic signed [lsfp_pkg::DIST_W-1:0] dist_checked;

   // Stall only while a response sits unclaimed
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign finish    = accept & (phase_ff == PH_CKSUM);
   assign sum_match = (req_rx_byte == sum_ff);

   // Distance validation by sensor type
   assign dist_raw = {dist_hi_ff, dist_lo_ff};
   always_comb begin
      dist_checked = lsfp_pkg::DIST_INVALID;
      if (sensor_ff == lsfp_pkg::SENSOR_SHORT) begin
         if (dist_raw >= lsfp_pkg::RANGE_MIN && dist_raw < lsfp_pkg::RANGE0_END) begin
            dist_checked = signed'(dist_raw[lsfp_pkg::DIST_W-1:0]);
            if (signal_ff == lsfp_pkg::LONG_ITIME) begin
               dist_checked = signed'(dist_raw[lsfp_pkg::DIST_W-1:0])
                            - lsfp_pkg::ITIME_OFFSET;
            end
         end
      end else begin
         if (dist_raw >= lsfp_pkg::RANGE_MIN && dist_raw < lsfp_pkg::RANGE1_END
             && signal_ff >= lsfp_pkg::SIG_MIN) begin
            dist_checked = signed'(dist_raw[lsfp_pkg::DIST_W-1:0]);
         end
      end
   end

   // Frame sequencing, running checksum, held distance and error count
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      held_in  = held_ff;
      err_in   = err_ff;
      if (accept) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (req_rx_byte == lsfp_pkg::SYNC_BYTE) phase_in = PH_SYNC2;
            end
            PH_SYNC2: begin
               phase_in = (req_rx_byte == lsfp_pkg::SYNC_BYTE) ? PH_PAYLOAD : PH_SYNC1;
               idx_in   = '0;
               sum_in   = lsfp_pkg::SUM_SEED;
            end
            PH_PAYLOAD: begin
               sum_in = sum_ff + req_rx_byte;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == lsfp_pkg::IDX_LAST) phase_in = PH_CKSUM;
            end
            PH_CKSUM: begin
               if (sum_match) held_in = dist_checked;
               else           err_in  = err_ff + 1'b1;
               phase_in = PH_SYNC1;
               idx_in   = '0;
            end
            default: phase_in = PH_SYNC1;
         endcase
      end
   end

   // Response register: loaded on the checksum byte, freed when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (finish)                     rsp_valid_in = 1'b1;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         idx_ff       <= '0;
         held_ff      <= '0;
         err_ff       <= '0;
         sensor_ff    <= lsfp_pkg::SENSOR_SHORT;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         held_ff      <= held_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) sensor_ff <= csr_write_data;
      end
   end

   // Payload: checksum, kept payload bytes, response flag
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (accept && phase_ff == PH_PAYLOAD) begin
         if (idx_ff == lsfp_pkg::IDX_DIST_LO) dist_lo_ff <= req_rx_byte;
         if (idx_ff == lsfp_pkg::IDX_DIST_HI) dist_hi_ff <= req_rx_byte;
         if (idx_ff == lsfp_pkg::IDX_SIGNAL)  signal_ff  <= req_rx_byte;
      end
      if (finish) rsp_ok_ff <= sum_match;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_checksum_ok = rsp_ok_ff;
   assign rsp_distance_cm = held_ff;
   assign rsp_error_count = err_ff;

`ifndef SYNTHESIS
   // A checksum byte always leaves a response behind
   a_finish_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("checksum byte gave no response");

   // A mismatch bumps the error count by exactly one
   a_err_step: assert property (@(posedge clock) disable iff (reset)
      (finish && !sum_match) |=> (err_ff == $past(err_ff) + 1'b1) && !rsp_ok_ff)
      else $error("error count not advanced on mismatch");

   // Errors and the held distance only move on a finished frame
   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      !finish |=> $stable(err_ff) && $stable(held_ff))
      else $error("held results changed without a checksum byte");

   // No byte moves the parser while stalled
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff) && $stable(idx_ff))
      else $error("parser advanced without an accepted request");

   // Payload index stays inside the frame
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (idx_ff <= lsfp_pkg::IDX_LAST))
      else $error("payload index beyond frame");
`endif

endmodule
`default_nettype wire
